/* src/horizontal_ridge_filter_binarize_top_macros.svh */
// assertion macros for horizontal_ridge_filter_binarize_top
// expects i_clk and i_rst_n in the scope of use
`ifndef HORIZONTAL_RIDGE_FILTER_BINARIZE_TOP_MACROS_SVH
`define HORIZONTAL_RIDGE_FILTER_BINARIZE_TOP_MACROS_SVH

// same-cycle implication
`define HRFB_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrfb check failed");

// next-cycle implication
`define HRFB_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrfb check failed");

`endif

/* src/hrfb_pkg.sv */
// shared types and constants for the horizontal ridge filter / binarizer
// no dependencies
`default_nettype none

package hrfb_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned SIZE_W = 10;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned SUM_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd2;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH = 10'd400;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 10'd400;
    localparam logic [PIX_W-1:0] RST_LEVEL_THRESHOLD = 8'd200;
    localparam logic [SIZE_W-1:0] MIN_FRAME_WIDTH = 10'd5;
    localparam logic [SIZE_W-1:0] MIN_FRAME_HEIGHT = 10'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    typedef struct packed {
        logic border;
        logic last;
    } t_pend_info;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flat;
    } t_level_res;

endpackage

`default_nettype wire

/* src/hrfb_store.sv */
// filtered sum memory, one write and one registered read port
// no package dependencies
`default_nettype none

module hrfb_store #(
    parameter int unsigned DEPTH = 262144,
    parameter int unsigned AW = 18,
    parameter int unsigned DW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/hrfb_level.sv */
// stretch-and-threshold compare of one stored sum against the frame range
// depends on hrfb_pkg
`default_nettype none

module hrfb_level (
    input  wire logic signed [hrfb_pkg::SUM_W-1:0] i_value,
    input  wire logic                              i_border,
    input  wire logic signed [hrfb_pkg::SUM_W-1:0] i_min,
    input  wire logic signed [hrfb_pkg::SUM_W-1:0] i_max,
    input  wire logic        [hrfb_pkg::PIX_W-1:0] i_threshold,
    output hrfb_pkg::t_level_res                   o_res
);
    import hrfb_pkg::*;

    logic signed [SUM_W:0] v;
    logic signed [SUM_W:0] dv;
    logic signed [SUM_W:0] span;
    logic        [SUM_W+PIX_W-1:0] lhs;
    logic        [SUM_W+PIX_W-1:0] rhs;

    always_comb begin
        v = i_border ? '0 : {i_value[SUM_W-1], i_value};
        dv = v - {i_min[SUM_W-1], i_min};
        span = {i_max[SUM_W-1], i_max} - {i_min[SUM_W-1], i_min};
        // 255 * dv as shift and subtract
        lhs = ({{(PIX_W-1){1'b0}}, dv[SUM_W-1:0], 1'b0} << (PIX_W - 1))
              - {{PIX_W{1'b0}}, dv[SUM_W-1:0]};
        rhs = (SUM_W+PIX_W)'(i_threshold) * (SUM_W+PIX_W)'(span[SUM_W-1:0]);
        o_res.flat = (i_max == i_min);
        if (o_res.flat) begin
            o_res.pixel = PIX_BLACK;
        end else begin
            o_res.pixel = (lhs >= rhs) ? PIX_WHITE : PIX_BLACK;
        end
    end

endmodule

`default_nettype wire

/* src/horizontal_ridge_filter_binarize_top.sv */
// horizontal ridge filter with frame min/max tracking and binarized readout
// depends on hrfb_pkg, hrfb_store, hrfb_level and the macros header
//
// input channel: i_in_valid / o_in_stall, one beat carries i_op and i_pixel_in.
//   op load writes one pixel of the frame in raster order; it yields no beat.
//   op read returns the next binarized pixel once a whole frame is loaded;
//   a read before that is taken and dropped.
// output channel: o_out_valid / i_out_stall with pixel, last and flat flags.
// a read issues one store read; the store registers the read data, which
// moves into the output register once that register is free. reads and loads may
// follow each other every cycle while the output keeps draining; the input
// stalls only when a read result is pending and the output register is held
// by a stall.
// configuration: plain write port; the user writes it only while the block is idle,
// which the block does not enforce; writing width or height restarts the frame.
// reset: synchronous active low, clears counters, taps, min/max and the
// output valid flag; the sum store needs no clearing since only complete frames
// are read.
`default_nettype none

`include "horizontal_ridge_filter_binarize_top_macros.svh"

module horizontal_ridge_filter_binarize_top #(
    parameter int unsigned MAX_WIDTH = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [hrfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hrfb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_op,
    input  wire logic [hrfb_pkg::PIX_W-1:0]          i_pixel_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [hrfb_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                                     o_last_pixel,
    output logic                                     o_flat_frame
);
    import hrfb_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIZE_W-1:0] r_frame_w;
    logic [SIZE_W-1:0] r_frame_h;
    logic [PIX_W-1:0]  r_thr;
    logic [PIX_W-1:0]  r_tap [4];
    logic [PIX_W-1:0]  n_tap [4];
    logic [SIZE_W-1:0] r_ld_col, n_ld_col;
    logic [SIZE_W-1:0] r_ld_row, n_ld_row;
    logic [AW-1:0]     r_ld_addr, n_ld_addr;
    logic signed [SUM_W-1:0] r_min, n_min;
    logic signed [SUM_W-1:0] r_max, n_max;
    logic [SIZE_W-1:0] r_ro_col, n_ro_col;
    logic [SIZE_W-1:0] r_ro_row, n_ro_row;
    logic [AW-1:0]     r_ro_addr, n_ro_addr;
    logic              r_ready, n_ready;
    logic              r_pend, n_pend;
    t_pend_info        r_pend_info, n_pend_info;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;
    logic              r_out_last, n_out_last;
    logic              r_out_flat, n_out_flat;

    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;
    logic              in_acc;
    logic              ld_acc;
    logic              rd_issue;
    logic              out_move;
    logic              frame_start;
    logic              sum_we;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]  rdata;
    t_level_res        lvl;

    always_comb begin
        if (r_frame_w < MIN_FRAME_WIDTH) begin
            eff_w = MIN_FRAME_WIDTH;
        end else if (32'(r_frame_w) > MAX_WIDTH) begin
            eff_w = SIZE_W'(MAX_WIDTH);
        end else begin
            eff_w = r_frame_w;
        end
        if (r_frame_h < MIN_FRAME_HEIGHT) begin
            eff_h = MIN_FRAME_HEIGHT;
        end else if (32'(r_frame_h) > MAX_HEIGHT) begin
            eff_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_h;
        end
    end

    assign out_move = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend && !out_move;
    assign in_acc = i_in_valid && !o_in_stall;
    assign ld_acc = in_acc && (i_op == OP_LOAD);
    assign rd_issue = in_acc && (i_op == OP_READ) && r_ready;
    assign frame_start = (r_ld_col == '0) && (r_ld_row == '0);
    assign sum_we = ld_acc && (r_ld_col >= SIZE_W'(4));

    // ridge kernel -1 0 2 0 -1 centered two columns back
    assign sum = $signed({2'b00, r_tap[1], 1'b0}) - $signed({3'b000, r_tap[3]})
                 - $signed({3'b000, i_pixel_in});

    hrfb_store #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (SUM_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (sum_we),
        .i_waddr(r_ld_addr - AW'(2)),
        .i_wdata(sum),
        .i_re   (rd_issue),
        .i_raddr(r_ro_addr),
        .o_rdata(rdata)
    );

    hrfb_level u_level (
        .i_value    ($signed(rdata)),
        .i_border   (r_pend_info.border),
        .i_min      (r_min),
        .i_max      (r_max),
        .i_threshold(r_thr),
        .o_res      (lvl)
    );

    always_comb begin
        n_tap = r_tap;
        n_ld_col = r_ld_col;
        n_ld_row = r_ld_row;
        n_ld_addr = r_ld_addr;
        n_min = r_min;
        n_max = r_max;
        n_ro_col = r_ro_col;
        n_ro_row = r_ro_row;
        n_ro_addr = r_ro_addr;
        n_ready = r_ready;
        n_pend = r_pend;
        n_pend_info = r_pend_info;
        n_out_valid = r_out_valid;
        n_out_pix = r_out_pix;
        n_out_last = r_out_last;
        n_out_flat = r_out_flat;

        if (ld_acc) begin
            if (frame_start) begin
                n_min = '0;
                n_max = '0;
                n_ready = 1'b0;
                n_ro_col = '0;
                n_ro_row = '0;
                n_ro_addr = '0;
            end
            if (sum_we) begin
                if (sum < n_min) begin
                    n_min = sum;
                end
                if (sum > n_max) begin
                    n_max = sum;
                end
            end
            n_tap[3] = r_tap[2];
            n_tap[2] = r_tap[1];
            n_tap[1] = r_tap[0];
            n_tap[0] = i_pixel_in;
            if (r_ld_col >= eff_w - SIZE_W'(1)) begin
                n_ld_col = '0;
                if (r_ld_row >= eff_h - SIZE_W'(1)) begin
                    n_ld_row = '0;
                    n_ld_addr = '0;
                    n_ready = 1'b1;
                    n_ro_col = '0;
                    n_ro_row = '0;
                    n_ro_addr = '0;
                end else begin
                    n_ld_row = r_ld_row + SIZE_W'(1);
                    n_ld_addr = r_ld_addr + AW'(1);
                end
            end else begin
                n_ld_col = r_ld_col + SIZE_W'(1);
                n_ld_addr = r_ld_addr + AW'(1);
            end
        end

        if (out_move) begin
            n_out_valid = r_pend;
            if (r_pend) begin
                n_out_pix = lvl.pixel;
                n_out_flat = lvl.flat;
                n_out_last = r_pend_info.last;
            end
            n_pend = 1'b0;
        end

        if (rd_issue) begin
            n_pend = 1'b1;
            n_pend_info.border = (r_ro_col < SIZE_W'(2)) || (r_ro_col >= eff_w - SIZE_W'(2));
            n_pend_info.last = (r_ro_row >= eff_h - SIZE_W'(1))
                               && (r_ro_col >= eff_w - SIZE_W'(1));
            if (n_pend_info.last) begin
                n_ready = 1'b0;
                n_ro_col = '0;
                n_ro_row = '0;
                n_ro_addr = '0;
            end else begin
                n_ro_addr = r_ro_addr + AW'(1);
                if (r_ro_col >= eff_w - SIZE_W'(1)) begin
                    n_ro_col = '0;
                    n_ro_row = r_ro_row + SIZE_W'(1);
                end else begin
                    n_ro_col = r_ro_col + SIZE_W'(1);
                end
            end
        end

        if (i_cfg_we && (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT)) begin
            n_ld_col = '0;
            n_ld_row = '0;
            n_ld_addr = '0;
            n_ro_col = '0;
            n_ro_row = '0;
            n_ro_addr = '0;
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= RST_FRAME_WIDTH;
            r_frame_h <= RST_FRAME_HEIGHT;
            r_thr <= RST_LEVEL_THRESHOLD;
            r_tap <= '{default: '0};
            r_ld_col <= '0;
            r_ld_row <= '0;
            r_ld_addr <= '0;
            r_min <= '0;
            r_max <= '0;
            r_ro_col <= '0;
            r_ro_row <= '0;
            r_ro_addr <= '0;
            r_ready <= 1'b0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: r_frame_w <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                    CFG_LEVEL_THRESHOLD: r_thr <= i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            r_tap <= n_tap;
            r_ld_col <= n_ld_col;
            r_ld_row <= n_ld_row;
            r_ld_addr <= n_ld_addr;
            r_min <= n_min;
            r_max <= n_max;
            r_ro_col <= n_ro_col;
            r_ro_row <= n_ro_row;
            r_ro_addr <= n_ro_addr;
            r_ready <= n_ready;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_info <= n_pend_info;
        r_out_pix <= n_out_pix;
        r_out_last <= n_out_last;
        r_out_flat <= n_out_flat;
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_last_pixel = r_out_last;
    assign o_flat_frame = r_out_flat;

    `HRFB_CHK_NOW(a_flat_black, o_out_valid && o_flat_frame, o_pixel_out == PIX_BLACK)
    `HRFB_CHK_NOW(a_pix_binary, o_out_valid, o_pixel_out == PIX_BLACK || o_pixel_out == PIX_WHITE)
    `HRFB_CHK_NOW(a_ready_at_origin, r_ready, r_ld_col == '0 && r_ld_row == '0)
    `HRFB_CHK_NOW(a_min_le_max, 1'b1, r_min <= 0 && r_max >= 0)

endmodule

`default_nettype wire

/* tb/horizontal_ridge_filter_binarize_checker.sv */
// checker for horizontal_ridge_filter_binarize_top: follows every accepted beat,
// predicts the binarized readout and compares the output stream field by field
// depends on hrfb_pkg
module horizontal_ridge_filter_binarize_checker #(
    parameter int unsigned MAX_WIDTH = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hrfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hrfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_op,
    input  logic [hrfb_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [hrfb_pkg::PIX_W-1:0]      i_pixel_out,
    input  logic                            i_last_pixel,
    input  logic                            i_flat_frame,
    output int                              o_mismatches,
    output int                              o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import hrfb_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             flat;
    } t_level_beat;

    logic signed [SUM_W-1:0] ridge_sum [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0]        taps [4];
    int unsigned             load_col;
    int unsigned             load_row;
    int unsigned             read_pos;
    int                      sum_lo;
    int                      sum_hi;
    bit                      frame_loaded;
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic [PIX_W-1:0]        thresh_reg;
    t_level_beat             due_levels [$];
    int                      mismatches = 0;
    int                      waiting = 0;

    assign o_mismatches = mismatches;
    assign o_waiting = waiting;

    function automatic int unsigned used_width();
        if (width_reg < MIN_FRAME_WIDTH) return MIN_FRAME_WIDTH;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg < MIN_FRAME_HEIGHT) return MIN_FRAME_HEIGHT;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void record_sum(int unsigned r, int unsigned c, int v);
        ridge_sum[r*used_width() + c] = v[SUM_W-1:0];
        if (v < sum_lo) sum_lo = v;
        if (v > sum_hi) sum_hi = v;
    endfunction

    function automatic void restart_frame();
        load_col = 0;
        load_row = 0;
        read_pos = 0;
        frame_loaded = 1'b0;
    endfunction

    // one accepted input beat; returns 1 when it yields an output beat
    function automatic bit ridge_level_step(logic op, logic [PIX_W-1:0] px,
                                            output t_level_beat beat);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int          v;
        w = used_width();
        h = used_height();
        beat = '0;
        if (op == OP_LOAD) begin
            c = load_col;
            r = load_row;
            if (r == 0 && c == 0) begin
                sum_lo = 0;
                sum_hi = 0;
                frame_loaded = 1'b0;
                read_pos = 0;
            end
            if (c < 2) record_sum(r, c, 0);
            if (c >= 4) record_sum(r, c - 2, 2*int'(taps[1]) - int'(taps[3]) - int'(px));
            taps[3] = taps[2];
            taps[2] = taps[1];
            taps[1] = taps[0];
            taps[0] = px;
            if (c + 1 >= w) begin
                record_sum(r, w - 2, 0);
                record_sum(r, w - 1, 0);
                load_col = 0;
                if (r + 1 >= h) begin
                    load_row = 0;
                    frame_loaded = 1'b1;
                    read_pos = 0;
                end else begin
                    load_row = r + 1;
                end
            end else begin
                load_col = c + 1;
            end
            return 1'b0;
        end
        if (!frame_loaded) return 1'b0;
        idx = read_pos;
        v = ridge_sum[idx];
        beat.pixel = PIX_BLACK;
        beat.last = (idx + 1 >= w*h);
        beat.flat = (sum_hi == sum_lo);
        if (!beat.flat && int'(PIX_WHITE)*(v - sum_lo) >= int'(thresh_reg)*(sum_hi - sum_lo))
            beat.pixel = PIX_WHITE;
        if (beat.last) begin
            read_pos = 0;
            frame_loaded = 1'b0;
        end else begin
            read_pos = idx + 1;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_level_beat want;
        t_level_beat fresh;
        if (!i_rst_n) begin
            width_reg = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            thresh_reg = RST_LEVEL_THRESHOLD;
            foreach (taps[k]) taps[k] = '0;
            sum_lo = 0;
            sum_hi = 0;
            restart_frame();
            due_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_LEVEL_THRESHOLD: begin
                        thresh_reg = i_cfg_data[PIX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_levels.size() == 0) begin
                    flag_mismatch("output beat with nothing due", 1, 0);
                end else begin
                    want = due_levels.pop_front();
                    if (i_pixel_out !== want.pixel)
                        flag_mismatch("pixel_out", i_pixel_out, want.pixel);
                    if (i_last_pixel !== want.last)
                        flag_mismatch("last_pixel", i_last_pixel, want.last);
                    if (i_flat_frame !== want.flat)
                        flag_mismatch("flat_frame", i_flat_frame, want.flat);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (ridge_level_step(i_op, i_pixel_in, fresh))
                    due_levels.insert(due_levels.size(), fresh);
            end
        end
        waiting <= due_levels.size();
    end

endmodule

/* tb/horizontal_ridge_filter_binarize_top_test.sv */
// top of the testbench for horizontal_ridge_filter_binarize_top: clock, reset,
// register writes, load and readout beats with random idling, and the verdict
// depends on hrfb_pkg, the block and horizontal_ridge_filter_binarize_checker
module horizontal_ridge_filter_binarize_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrfb_pkg::*;

    localparam int unsigned MAX_WIDTH = 512;
    localparam int unsigned MAX_HEIGHT = 512;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned ITEM_TARGET = 1500;
    localparam int unsigned CALM_ITEMS = 200;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_RAW_SIZE = 1023;
    localparam int unsigned WIDE_PHASE = 5;
    localparam int unsigned HOLD_PHASE = 9;
    localparam int unsigned TALL_PHASE = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int STYLE_RANDOM = 0;
    localparam int STYLE_FLAT = 1;
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_NEAR = 3;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  in_op = OP_LOAD;
    logic [PIX_W-1:0]      in_pixel = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  out_last;
    logic                  out_flat;
    int                    mismatches;
    int                    waiting;

    int unsigned cycle_count = 0;
    int unsigned beats_sent = 0;
    int unsigned cur_w = RST_FRAME_WIDTH;
    int unsigned cur_h = RST_FRAME_HEIGHT;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          calm = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;

    horizontal_ridge_filter_binarize_top #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_op(in_op),
        .i_pixel_in(in_pixel),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_pixel_out(out_pixel),
        .o_last_pixel(out_last),
        .o_flat_frame(out_flat)
    );

    horizontal_ridge_filter_binarize_checker #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) level_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_op(in_op),
        .i_pixel_in(in_pixel),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_pixel_out(out_pixel),
        .i_last_pixel(out_last),
        .i_flat_frame(out_flat),
        .o_mismatches(mismatches),
        .o_waiting(waiting)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // output side: random stall bursts plus the requested long hold
    initial begin
        forever begin
            @(posedge clk);
            if (holds_done != holds_asked) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                out_stall <= 1'b0;
            end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(int style, logic [PIX_W-1:0] level);
        case (style)
            STYLE_FLAT:    return level;
            STYLE_EXTREME: return $urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK;
            STYLE_NEAR:    return level ^ PIX_W'($urandom_range(0, 3));
            default:       return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic [PIX_W-1:0] px);
        if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_pixel <= px;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_size(input int unsigned raw_w, input int unsigned raw_h);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(raw_w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(raw_h));
        cur_w = raw_w < MIN_FRAME_WIDTH ? MIN_FRAME_WIDTH : (raw_w > MAX_WIDTH ? MAX_WIDTH : raw_w);
        cur_h = raw_h < MIN_FRAME_HEIGHT ? MIN_FRAME_HEIGHT :
                (raw_h > MAX_HEIGHT ? MAX_HEIGHT : raw_h);
    endtask

    task automatic pick_size();
        set_size(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
    endtask

    // stray reads mixed in are dropped by the block while a frame is loading
    task automatic load_frame(input int unsigned n, input int style, input int unsigned noise_pct);
        logic [PIX_W-1:0] level;
        level = $urandom_range(0, 255);
        for (int unsigned k = 0; k < n; k++) begin
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) send_beat(OP_READ, level);
            send_beat(OP_LOAD, pick_pixel(style, level));
            beats_sent++;
        end
    endtask

    task automatic read_pixels(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_beat(OP_READ, PIX_W'($urandom_range(0, 255)));
            beats_sent++;
        end
    endtask

    initial begin
        logic [PIX_W-1:0] ridge_row [5];
        logic [PIX_W-1:0] thr;
        int unsigned      phase;
        int unsigned      kind;
        int unsigned      total;
        int               style;

        ridge_row = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, peak sum at full threshold, then one read past the end
        write_reg(CFG_LEVEL_THRESHOLD, 10'h3ff);
        set_size(0, 0);
        foreach (ridge_row[k]) send_beat(OP_LOAD, ridge_row[k]);
        read_pixels(6);
        // negative peak, zero threshold, readout cut short by a new frame
        foreach (ridge_row[k]) send_beat(OP_LOAD, ~ridge_row[k]);
        write_reg(CFG_LEVEL_THRESHOLD, '0);
        read_pixels(2);
        load_frame(5, STYLE_FLAT, 0);
        read_pixels(2);
        // width write drops the rest of the readout
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
        read_pixels(1);

        beats_sent = 0;
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            phase++;
            calm = (beats_sent + CALM_ITEMS >= ITEM_TARGET);
            if (calm) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0, 1: gap_pct = 0;
                    2: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            if (phase == WIDE_PHASE) begin
                set_size(MAX_RAW_SIZE, 1);
                load_frame(cur_w, STYLE_RANDOM, 0);
                read_pixels(cur_w);
            end else if (phase == HOLD_PHASE) begin
                set_size(16, 4);
                load_frame(cur_w*cur_h, STYLE_RANDOM, 0);
                holds_asked++;
                read_pixels(cur_w*cur_h);
            end else if (phase == TALL_PHASE) begin
                set_size(5, MAX_RAW_SIZE);
                load_frame(8*cur_w, STYLE_RANDOM, 20);
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
                cur_h = 2;
                load_frame(cur_w*cur_h, STYLE_EXTREME, 0);
                read_pixels(cur_w*cur_h);
            end else begin
                if (phase == 1 || $urandom_range(0, 3) != 0) pick_size();
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 3))
                        0: thr = '0;
                        1: thr = PIX_WHITE;
                        default: thr = PIX_W'($urandom_range(0, 255));
                    endcase
                    write_reg(CFG_LEVEL_THRESHOLD, {2'($urandom_range(0, 3)), thr});
                end
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, MAX_RAW_SIZE)));
                style = $urandom_range(STYLE_RANDOM, STYLE_NEAR);
                kind = $urandom_range(0, 9);
                total = cur_w*cur_h;
                if (kind == 0) begin
                    load_frame($urandom_range(1, total), style, 10);
                    pick_size();
                    total = cur_w*cur_h;
                end
                load_frame(total, style, (kind == 1) ? 15 : 0);
                if (kind == 2)
                    read_pixels($urandom_range(1, total - 1));
                else
                    read_pixels(total + ((kind == 3) ? $urandom_range(1, 3) : 0));
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
